FILE: hw/rtl/unsorted_priority_queue_assert.svh
// Assertion helpers, clocked on clk and disabled while rst_n is low.
`ifndef UNSORTED_PRIORITY_QUEUE_ASSERT_SVH
`define UNSORTED_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication.
`define UPQ_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("upq assertion failed");

// Next-cycle implication.
`define UPQ_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("upq assertion failed");

`endif

FILE: hw/rtl/upq_pkg.sv
package upq_pkg;

  localparam int DATA_W = 32;
  localparam int CNT_OUT_W = 5;

  localparam logic [1:0] OP_INSERT  = 2'd0;
  localparam logic [1:0] OP_EXTRACT = 2'd1;
  localparam logic [1:0] OP_PEEK    = 2'd2;
  localparam logic [1:0] OP_MODIFY  = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_ROTATE,
    CMD_WRITE,
    CMD_CLOSE,
    CMD_SETPRI
  } upq_cmd_t;

  typedef struct packed {
    upq_cmd_t                  cmd;
    logic signed [DATA_W-1:0]  val;
    logic signed [DATA_W-1:0]  pri;
  } upq_cell_ctl_t;

endpackage

FILE: hw/rtl/upq_if.sv
interface upq_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           opcode;
  logic signed [upq_pkg::DATA_W-1:0]    item_value;
  logic signed [upq_pkg::DATA_W-1:0]    item_priority;

  modport source (output valid, output opcode, output item_value, output item_priority,
                  input ready);
  modport sink (input valid, input opcode, input item_value, input item_priority,
                output ready);
endinterface

interface upq_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [upq_pkg::DATA_W-1:0]    result_value;
  logic [1:0]                           status;
  logic [upq_pkg::CNT_OUT_W-1:0]        entry_count;

  modport source (output valid, output result_value, output status, output entry_count,
                  input ready);
  modport sink (input valid, input result_value, input status, input entry_count,
                output ready);
endinterface

FILE: hw/rtl/upq_cell.sv
module upq_cell #(
  parameter int IDX = 0,
  parameter int IW  = 4
) (
  input  logic                              clk,
  input  upq_pkg::upq_cell_ctl_t            ctl,
  input  logic [IW-1:0]                     pos,
  input  logic signed [upq_pkg::DATA_W-1:0] nb_val,
  input  logic signed [upq_pkg::DATA_W-1:0] nb_pri,
  output logic signed [upq_pkg::DATA_W-1:0] val,
  output logic signed [upq_pkg::DATA_W-1:0] pri
);

  logic signed [upq_pkg::DATA_W-1:0] val_r, val_nxt;
  logic signed [upq_pkg::DATA_W-1:0] pri_r, pri_nxt;
  logic                              hit;
  logic                              at_or_after;

  assign hit         = (pos == IW'(IDX));
  assign at_or_after = (pos <= IW'(IDX));

  always_comb begin
    val_nxt = val_r;
    pri_nxt = pri_r;
    unique case (ctl.cmd)
      upq_pkg::CMD_HOLD: begin
      end
      upq_pkg::CMD_ROTATE: begin
        val_nxt = nb_val;
        pri_nxt = nb_pri;
      end
      upq_pkg::CMD_WRITE: begin
        if (hit) begin
          val_nxt = ctl.val;
          pri_nxt = ctl.pri;
        end
      end
      upq_pkg::CMD_CLOSE: begin
        if (at_or_after) begin
          val_nxt = nb_val;
          pri_nxt = nb_pri;
        end
      end
      upq_pkg::CMD_SETPRI: begin
        if (hit) begin
          pri_nxt = ctl.pri;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    pri_r <= pri_nxt;
  end

  assign val = val_r;
  assign pri = pri_r;

endmodule

FILE: hw/rtl/unsorted_priority_queue.sv
// Max priority queue of up to CAPACITY (value, priority) pairs kept in arrival order.
// in_ch carries opcode, item_value and item_priority; out_ch returns one item per
// accepted item: result_value, status and entry_count (entries held afterwards).
// Both channels use valid/ready; an item moves on a clock edge with both high.
// Entries live in a ring of cells; cell 0 is the head that the control logic reads.
// Insert, and extract/peek/modify on an empty queue, finish without a scan: they go
// from S_IDLE straight to S_FIN, and no new item is taken until S_IDLE is back.
// Extract, peek and modify rotate the whole ring once, one cell per cycle, comparing
// at the head; then S_UPD closes the gap (extract) or rewrites a priority (modify).
// Their result then passes through S_FIN, and no new item is taken until S_IDLE is back.
// Ties go to the oldest entry; modify changes the oldest entry with a matching value.
// A result waits in the output register while out_ch.ready is low, and the next item
// is accepted and worked on meanwhile; only its own result then waits behind it.
// Reset (rst_n low, synchronous) empties the queue and the output register; cell
// contents are not cleared and are never read before being written.
module unsorted_priority_queue #(
  parameter int CAPACITY = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  upq_in_if.sink    in_ch,
  upq_out_if.source out_ch
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int DW = upq_pkg::DATA_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]                      state_r, state_nxt;
  logic [CW-1:0]                   count_r, count_nxt;
  logic [IW-1:0]                   k_r, k_nxt;
  logic                            out_valid_r, out_valid_nxt;

  logic [1:0]                      op_r, op_nxt;
  logic signed [DW-1:0]            val_r, val_nxt;
  logic signed [DW-1:0]            pri_r, pri_nxt;
  logic [IW-1:0]                   best_idx_r, best_idx_nxt;
  logic signed [DW-1:0]            best_val_r, best_val_nxt;
  logic signed [DW-1:0]            best_pri_r, best_pri_nxt;
  logic                            found_r, found_nxt;
  logic signed [DW-1:0]            res_val_r, res_val_nxt;
  logic [1:0]                      res_st_r, res_st_nxt;
  logic signed [DW-1:0]            out_val_r, out_val_nxt;
  logic [1:0]                      out_st_r, out_st_nxt;
  logic [upq_pkg::CNT_OUT_W-1:0]   out_cnt_r, out_cnt_nxt;

  upq_pkg::upq_cell_ctl_t          ctl;
  logic [IW-1:0]                   pos;
  logic                            in_acc;
  logic                            live;

  logic signed [DW-1:0] cell_val [CAPACITY];
  logic signed [DW-1:0] cell_pri [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    upq_cell #(
      .IDX(i),
      .IW (IW)
    ) u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .pos   (pos),
      .nb_val(cell_val[(i + 1) % CAPACITY]),
      .nb_pri(cell_pri[(i + 1) % CAPACITY]),
      .val   (cell_val[i]),
      .pri   (cell_pri[i])
    );
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign live        = (CW'(k_r) < count_r);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r;
    op_nxt        = op_r;
    val_nxt       = val_r;
    pri_nxt       = pri_r;
    best_idx_nxt  = best_idx_r;
    best_val_nxt  = best_val_r;
    best_pri_nxt  = best_pri_r;
    found_nxt     = found_r;
    res_val_nxt   = res_val_r;
    res_st_nxt    = res_st_r;
    out_val_nxt   = out_val_r;
    out_st_nxt    = out_st_r;
    out_cnt_nxt   = out_cnt_r;
    ctl.cmd       = upq_pkg::CMD_HOLD;
    ctl.val       = in_ch.item_value;
    ctl.pri       = in_ch.item_priority;
    pos           = count_r[IW-1:0];

    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt      = in_ch.opcode;
          val_nxt     = in_ch.item_value;
          pri_nxt     = in_ch.item_priority;
          found_nxt   = 1'b0;
          k_nxt       = '0;
          res_val_nxt = '0;
          res_st_nxt  = upq_pkg::ST_OK;
          unique case (in_ch.opcode)
            upq_pkg::OP_INSERT: begin
              state_nxt = S_FIN;
              if (count_r == CW'(CAPACITY)) begin
                res_st_nxt = upq_pkg::ST_FULL;
              end else begin
                ctl.cmd   = upq_pkg::CMD_WRITE;
                count_nxt = count_r + 1'b1;
              end
            end
            upq_pkg::OP_EXTRACT, upq_pkg::OP_PEEK: begin
              if (count_r == '0) begin
                res_st_nxt = upq_pkg::ST_EMPTY;
                state_nxt  = S_FIN;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            upq_pkg::OP_MODIFY: begin
              if (count_r == '0) begin
                res_st_nxt = upq_pkg::ST_NOTFOUND;
                state_nxt  = S_FIN;
              end else begin
                state_nxt = S_SCAN;
              end
            end
          endcase
        end
      end
      S_SCAN: begin
        ctl.cmd = upq_pkg::CMD_ROTATE;
        if (live) begin
          if (op_r == upq_pkg::OP_MODIFY) begin
            if (!found_r && (cell_val[0] == val_r)) begin
              found_nxt    = 1'b1;
              best_idx_nxt = k_r;
            end
          end else if ((k_r == '0) || (cell_pri[0] > best_pri_r)) begin
            best_idx_nxt = k_r;
            best_val_nxt = cell_val[0];
            best_pri_nxt = cell_pri[0];
          end
        end
        if (k_r == IW'(CAPACITY - 1)) begin
          k_nxt     = '0;
          state_nxt = S_UPD;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_UPD: begin
        pos       = best_idx_r;
        ctl.pri   = pri_r;
        state_nxt = S_FIN;
        unique case (op_r)
          upq_pkg::OP_EXTRACT: begin
            ctl.cmd     = upq_pkg::CMD_CLOSE;
            count_nxt   = count_r - 1'b1;
            res_val_nxt = best_val_r;
          end
          upq_pkg::OP_PEEK: begin
            res_val_nxt = best_val_r;
          end
          upq_pkg::OP_MODIFY: begin
            if (found_r) begin
              ctl.cmd = upq_pkg::CMD_SETPRI;
            end else begin
              res_st_nxt = upq_pkg::ST_NOTFOUND;
            end
          end
          upq_pkg::OP_INSERT: begin
          end
        endcase
      end
      S_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = res_val_r;
          out_st_nxt    = res_st_r;
          out_cnt_nxt   = upq_pkg::CNT_OUT_W'(count_r);
          state_nxt     = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    val_r      <= val_nxt;
    pri_r      <= pri_nxt;
    best_idx_r <= best_idx_nxt;
    best_val_r <= best_val_nxt;
    best_pri_r <= best_pri_nxt;
    found_r    <= found_nxt;
    res_val_r  <= res_val_nxt;
    res_st_r   <= res_st_nxt;
    out_val_r  <= out_val_nxt;
    out_st_r   <= out_st_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_value = out_val_r;
  assign out_ch.status       = out_st_r;
  assign out_ch.entry_count  = out_cnt_r;

`include "unsorted_priority_queue_assert.svh"

  `UPQ_ASSERT_IMP(a_count_cap, 1'b1, count_r <= CW'(CAPACITY))
  `UPQ_ASSERT_NXT(a_insert_grows, in_acc && (in_ch.opcode == upq_pkg::OP_INSERT) && (count_r < CW'(CAPACITY)), count_r == $past(count_r) + 1'b1)
  `UPQ_ASSERT_IMP(a_scan_idle, state_r != S_SCAN, k_r == '0)
  `UPQ_ASSERT_NXT(a_scan_nonempty, in_acc && (in_ch.opcode != upq_pkg::OP_INSERT) && (count_r == '0), state_r == S_FIN)

endmodule
